// ===== hw/rtl/mrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus RTU response checker.
`default_nettype none

package mrc_pkg;

    // Frame length limit and derived widths
    localparam int MAX_FRAME   = 256;
    localparam int POS_W       = $clog2(MAX_FRAME + 1);
    localparam int IDX_W       = POS_W - 1;
    localparam int CMP_W       = (IDX_W > 7) ? IDX_W : 7;
    localparam int LEN_W       = (POS_W > 9) ? POS_W : 9;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START = 8'd3;

    // Protocol constants
    localparam logic [7:0]  FC_READ   = 8'd4;
    localparam logic [7:0]  FC_WRITE  = 8'd16;
    localparam logic [7:0]  EXC_FLAG  = 8'h80;
    localparam logic [15:0] CRC_INIT  = 16'hffff;
    localparam logic [15:0] CRC_POLY  = 16'ha001;
    localparam logic [LEN_W-1:0] MIN_LEN   = LEN_W'(5);
    localparam logic [LEN_W-1:0] WRITE_LEN = LEN_W'(8);

    // Result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_CRC       = 4'd2,
        ST_SLAVE     = 4'd3,
        ST_EXCEPTION = 4'd4,
        ST_FUNCTION  = 4'd5,
        ST_LENGTH    = 4'd6,
        ST_BYTECOUNT = 4'd7,
        ST_ECHO      = 4'd8
    } t_status;

    typedef struct packed {
        logic [7:0]  slave;
        logic        mode;
        logic [6:0]  count;
        logic [15:0] start;
    } t_cfg;

    // One classified byte, as the front hands it to the back
    typedef struct packed {
        logic [7:0]       rx_byte;
        logic             eof;
        logic             first;
        logic             stored;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] count;
        logic             overlong;
    } t_item;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mrc_front.sv =====
// Front end: accepts received words, tracks the byte position and classifies each word.
`default_nettype none

module mrc_front
    import mrc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire logic  i_space,
    input  wire logic  [7:0] i_rx_byte,
    input  wire logic  i_end_of_frame,
    output logic       o_ready,
    output logic       o_push,
    output t_item      o_item
);

    logic [POS_W-1:0] r_pos;
    logic             r_overlong;
    logic [POS_W-1:0] n_pos;
    logic             n_overlong;
    logic             stored;

    always_comb begin
        stored         = !r_overlong && (r_pos < POS_W'(MAX_FRAME));
        o_ready        = i_space;
        o_push         = i_valid && i_space;
        o_item.rx_byte = i_rx_byte;
        o_item.eof     = i_end_of_frame;
        o_item.first   = (r_pos == '0) && !r_overlong;
        o_item.stored  = stored;
        o_item.pos     = r_pos;
        o_item.count   = stored ? r_pos + POS_W'(1) : r_pos;
        o_item.overlong = !stored;
        // drop the frame count at the last word
        if (i_end_of_frame) begin
            n_pos      = '0;
            n_overlong = 1'b0;
        end else begin
            n_pos      = o_item.count;
            n_overlong = !stored;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_overlong <= 1'b0;
        end else if (o_push) begin
            r_pos      <= n_pos;
            r_overlong <= n_overlong;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mrc_queue.sv =====
// Short queue of classified words between the front and the back.
`default_nettype none

module mrc_queue
    import mrc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  t_item      i_item,
    output logic       o_space,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    t_item             r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_space = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mrc_back.sv =====
// Back end: CRC, header capture, register words and frame status into the output register.
`default_nettype none

module mrc_back
    import mrc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_cfg       i_cfg,
    input  wire logic  i_valid,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic       o_kind,
    output logic [6:0] o_reg_index,
    output logic [15:0] o_reg_value,
    output logic [3:0] o_status,
    output logic [7:0] o_exception_code
);

    logic [15:0] r_crc;
    logic [7:0]  r_held;
    logic [7:0]  r_addr;
    logic [7:0]  r_func;
    logic [7:0]  r_third;
    logic [15:0] r_echo_start;
    logic [15:0] r_echo_count;
    logic [7:0]  r_pending;

    logic        r_out_valid;
    logic        r_kind;
    logic [6:0]  r_reg_index;
    logic [15:0] r_reg_value;
    t_status     r_status;
    logic [7:0]  r_exc;

    logic             take;
    logic             odd_high;
    logic [CMP_W-1:0] idx;
    logic             emit_word;
    logic [7:0]       fc;
    logic [LEN_W-1:0] n_len;
    logic [LEN_W-1:0] exp_len;
    logic [15:0]      received;
    t_status          status;
    logic [7:0]       exc;

    always_comb begin
        take      = !r_out_valid || i_out_ready;
        o_pop     = i_valid && take;
        odd_high  = (i_item.pos >= POS_W'(3)) && i_item.pos[0];
        idx       = CMP_W'((i_item.pos - POS_W'(4)) >> 1);
        emit_word = i_item.stored && !odd_high && !i_item.eof && !i_cfg.mode
                    && (i_item.pos >= POS_W'(4)) && (idx < CMP_W'(i_cfg.count));
        fc        = i_cfg.mode ? FC_WRITE : FC_READ;
        n_len     = LEN_W'(i_item.count);
        exp_len   = MIN_LEN + (LEN_W'(i_cfg.count) << 1);
        received  = {i_item.rx_byte, r_held};
        exc       = 8'h00;
        // checks in priority order
        if (!i_item.overlong && (n_len < MIN_LEN)) begin
            status = ST_SHORT;
        end else if (received != r_crc) begin
            status = ST_CRC;
        end else if (r_addr != i_cfg.slave) begin
            status = ST_SLAVE;
        end else if (r_func == (fc | EXC_FLAG)) begin
            status = ST_EXCEPTION;
            exc    = r_third;
        end else if (r_func != fc) begin
            status = ST_FUNCTION;
        end else if (!i_cfg.mode) begin
            if (i_item.overlong || (n_len != exp_len)) begin
                status = ST_LENGTH;
            end else if (r_third != {i_cfg.count, 1'b0}) begin
                status = ST_BYTECOUNT;
            end else begin
                status = ST_OK;
            end
        end else begin
            if (i_item.overlong || (n_len != WRITE_LEN)) begin
                status = ST_LENGTH;
            end else if ((r_echo_start != i_cfg.start)
                         || (r_echo_count != {9'd0, i_cfg.count})) begin
                status = ST_ECHO;
            end else begin
                status = ST_OK;
            end
        end
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc        <= CRC_INIT;
            r_held       <= '0;
            r_addr       <= '0;
            r_func       <= '0;
            r_third      <= '0;
            r_echo_start <= '0;
            r_echo_count <= '0;
            r_pending    <= '0;
        end else if (o_pop) begin
            if (i_item.eof) begin
                r_crc        <= CRC_INIT;
                r_held       <= '0;
                r_addr       <= '0;
                r_func       <= '0;
                r_third      <= '0;
                r_echo_start <= '0;
                r_echo_count <= '0;
                r_pending    <= '0;
            end else begin
                // CRC trails the input by one word
                if (!i_item.first) begin
                    r_crc <= crc_fold(r_crc, r_held);
                end
                r_held <= i_item.rx_byte;
                if (i_item.stored) begin
                    if (i_item.pos == POS_W'(0)) begin
                        r_addr <= i_item.rx_byte;
                    end
                    if (i_item.pos == POS_W'(1)) begin
                        r_func <= i_item.rx_byte;
                    end
                    if (i_item.pos == POS_W'(2)) begin
                        r_third            <= i_item.rx_byte;
                        r_echo_start[15:8] <= i_item.rx_byte;
                    end
                    if (i_item.pos == POS_W'(3)) begin
                        r_echo_start[7:0] <= i_item.rx_byte;
                    end
                    if (i_item.pos == POS_W'(4)) begin
                        r_echo_count[15:8] <= i_item.rx_byte;
                    end
                    if (i_item.pos == POS_W'(5)) begin
                        r_echo_count[7:0] <= i_item.rx_byte;
                    end
                    if (odd_high) begin
                        r_pending <= i_item.rx_byte;
                    end
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && (emit_word || i_item.eof)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.eof) begin
            r_kind      <= KIND_STATUS;
            r_reg_index <= '0;
            r_reg_value <= '0;
            r_status    <= status;
            r_exc       <= exc;
        end else if (o_pop && emit_word) begin
            r_kind      <= KIND_WORD;
            r_reg_index <= idx[6:0];
            r_reg_value <= {r_pending, i_item.rx_byte};
            r_status    <= ST_OK;
            r_exc       <= '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_reg_index      = r_reg_index;
    assign o_reg_value      = r_reg_value;
    assign o_status         = r_status;
    assign o_exception_code = r_exc;

endmodule

`default_nettype wire

// ===== hw/rtl/modbus_rtu_response_checker_core.sv =====
// Modbus RTU response checker: top level with configuration registers and assertions.
//
// Usage: received response bytes enter on the in channel (i_rx_byte, i_end_of_frame set on
// the last byte of a frame). Results leave on the out channel: in read mode (function 4)
// one provisional register word per completed big-endian pair inside the requested count,
// and for every frame one status word at its last byte (o_kind high). Register words of a
// frame are valid only if that frame's status is ok.
// Configuration: write index 0 slave, 1 mode, 2 count, 3 start address on the cfg channel
// between frames; o_cfg_ready is always high.
// Throughput: one byte per cycle unless the receiver stalls. The front counts positions, a
// two-entry queue decouples it from the back, which folds the CRC-16 one byte per cycle and
// drives the output register; an accepted byte is queued before its result is registered.
// Reset clears the frame state and sets the registers to slave 1, mode 0, count 1, start 0.
// When the receiver stalls, the output register holds its word; the queue fills behind it
// and o_in_ready falls once both entries are taken.
`default_nettype none

module modbus_rtu_response_checker_core
    import mrc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [7:0]            i_rx_byte,
    input  wire logic                  i_end_of_frame,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_kind,
    output logic [6:0]                 o_reg_index,
    output logic [15:0]                o_reg_value,
    output logic [3:0]                 o_status,
    output logic [7:0]                 o_exception_code,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_item front_item;
    t_item queue_item;
    logic  front_push;
    logic  queue_space;
    logic  queue_valid;
    logic  back_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave <= 8'd1;
            r_cfg.mode  <= 1'b0;
            r_cfg.count <= 7'd1;
            r_cfg.start <= 16'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SLAVE: r_cfg.slave <= i_cfg_data[7:0];
                CFG_MODE:  r_cfg.mode  <= i_cfg_data[0];
                CFG_COUNT: r_cfg.count <= i_cfg_data[6:0];
                CFG_START: r_cfg.start <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mrc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_space        (queue_space),
        .i_rx_byte      (i_rx_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_ready        (o_in_ready),
        .o_push         (front_push),
        .o_item         (front_item)
    );

    mrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_space (queue_space),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    mrc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_valid          (queue_valid),
        .i_item           (queue_item),
        .o_pop            (back_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_reg_index      (o_reg_index),
        .o_reg_value      (o_reg_value),
        .o_status         (o_status),
        .o_exception_code (o_exception_code)
    );

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_exc_only_on_exception: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_EXCEPTION)) |-> (o_exception_code == 8'h00))
        else $error("exception code without exception status");

    a_word_only_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_WORD)) |-> !r_cfg.mode)
        else $error("register word in write mode");

    a_word_index_in_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == KIND_WORD)) |-> (o_reg_index < r_cfg.count))
        else $error("register word beyond requested count");

endmodule

`default_nettype wire
